/* hdl/teqs_pkg.sv */
// Package: shared constants and types for the timed event queue scheduler
package teqs_pkg;
   localparam int NUM_QUEUES  = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int QW          = $clog2(NUM_QUEUES);
   localparam int FW          = $clog2(QUEUE_DEPTH + 1);
   localparam logic [63:0] FF64 = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      CMD_INSERT  = 2'd0,
      CMD_POP     = 2'd1,
      CMD_ADVANCE = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NONE      = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY_ALL = 2'd3
   } status_type;

   typedef struct packed {
      logic [63:0] time_v;
      logic [7:0]  handle;
   } entry_type;

   // Per-queue operation broadcast to every cell of one queue
   typedef struct packed {
      logic        ins;
      logic        pop;
      logic [63:0] ins_time;
      logic [7:0]  ins_handle;
   } qop_type;
endpackage

/* hdl/teqs_if.sv */
// Interfaces: request and response channels
interface teqs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [2:0]  queue_index;
   logic [63:0] event_time;
   logic [7:0]  event_handle;
   modport source (output valid, command, queue_index, event_time, event_handle, input ready);
   modport sink (input valid, command, queue_index, event_time, event_handle, output ready);
endinterface

interface teqs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  popped_handle;
   logic [63:0] popped_time;
   logic [7:0]  due_mask;
   logic [63:0] time_now;
   modport source (output valid, status, popped_handle, popped_time, due_mask, time_now,
                   input ready);
   modport sink (input valid, status, popped_handle, popped_time, due_mask, time_now,
                 output ready);
endinterface

/* hdl/teqs_cell.sv */
// One queue slot: holds an entry and shifts with its neighbours on insert or pop
module teqs_cell (
   input  logic                clock,
   input  teqs_pkg::qop_type   op,
   input  logic                occ,       // this slot holds an entry
   input  logic                prev_occ,  // neighbour towards the head holds an entry
   input  teqs_pkg::entry_type prev,      // neighbour towards the head
   input  teqs_pkg::entry_type next,      // neighbour towards the tail
   input  logic                prev_gt,   // neighbour towards the head is later than new
   output teqs_pkg::entry_type cur,
   output logic                gt         // this entry is later than the new event
);
   import teqs_pkg::*;

   entry_type data_ff, data_in;

   assign cur = data_ff;
   assign gt  = occ && (data_ff.time_v > op.ins_time);

   // Insert: later entries move one towards the tail; pop: all move towards the head
   always_comb begin
      data_in = data_ff;
      if (op.ins) begin
         if (prev_occ && prev_gt) begin
            data_in = prev;
         end else if (gt || !occ) begin
            if (!(prev_occ == 1'b0 && occ == 1'b0) || !prev_occ) begin
               data_in = '{time_v: op.ins_time, handle: op.ins_handle};
            end
         end
      end else if (op.pop) begin
         data_in = next;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end
endmodule

/* hdl/teqs_queue.sv */
// One queue: a row of slot cells plus its fill count
module teqs_queue (
   input  logic                clock,
   input  logic                reset,
   input  teqs_pkg::qop_type   op,
   output teqs_pkg::entry_type head,
   output logic [teqs_pkg::FW-1:0] fill
);
   import teqs_pkg::*;

   logic [FW-1:0] fill_ff, fill_in;
   entry_type     cur [QUEUE_DEPTH];
   logic          gt  [QUEUE_DEPTH];
   logic          occ [QUEUE_DEPTH];

   assign fill = fill_ff;
   assign head = cur[0];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type nx;
      assign occ[i] = (FW'(i) < fill_ff);
      if (i + 1 < QUEUE_DEPTH) begin : g_n
         assign nx = cur[i+1];
      end else begin : g_l
         assign nx = cur[i];
      end
      if (i == 0) begin : g_h
         teqs_cell u_cell (.clock, .op, .occ(occ[i]), .prev_occ(1'b0), .prev(cur[i]),
                           .next(nx), .prev_gt(1'b0), .cur(cur[i]), .gt(gt[i]));
      end else begin : g_b
         teqs_cell u_cell (.clock, .op, .occ(occ[i]), .prev_occ(occ[i-1]),
                           .prev(cur[i-1]), .next(nx), .prev_gt(gt[i-1]),
                           .cur(cur[i]), .gt(gt[i]));
      end
   end

   // Fill count
   always_comb begin
      fill_in = fill_ff;
      if (op.ins) fill_in = fill_ff + FW'(1);
      else if (op.pop) fill_in = fill_ff - FW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) fill_ff <= '0;
      else fill_ff <= fill_in;
   end
endmodule

/* hdl/timed_event_queue_scheduler_core.sv */
// Top level: timed event queue scheduler
// A request is captured in S_IDLE when it is accepted and executed in S_EXEC: the queue
// rows shift (insert or pop) or the head comparison of an advance is resolved, and the
// response is registered at the end of the execute cycle, once the response register
// is free or being emptied. The response register parts the two sides, so the next request may be
// accepted while a response waits; it executes once that response has been handed over.
// No new request is taken while one waits in execute, and a response stall holds a
// request in execute until the response register is free or being emptied. Queue
// slots are shift-register cells, each queue inserting in order by a single shift; the head
// compare over all queues sets the execute cycle. Slot contents have no reset; only the state,
// fill counts, the time and the response valid are cleared.
module timed_event_queue_scheduler_core (
   input logic clock,
   input logic reset,
   teqs_req_if.sink   req,
   teqs_rsp_if.source rsp
);
   import teqs_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_EXEC} state_type;

   state_type     state_ff;
   logic [1:0]    cmd_ff;
   logic [2:0]    q_ff;
   logic [63:0]   t_ff;
   logic [7:0]    h_ff;
   logic [63:0]   now_ff;
   logic [1:0]    st_ff;
   logic [7:0]    ph_ff, mask_ff;
   logic [63:0]   pt_ff;
   logic          rsp_valid_ff;

   qop_type        ops   [NUM_QUEUES];
   entry_type      heads [NUM_QUEUES];
   logic [FW-1:0]  fills [NUM_QUEUES];

   logic          qok;
   logic [QW-1:0] qi;
   logic [NUM_QUEUES-1:0] ne, due, at_min;
   logic [63:0]   earliest;
   logic [1:0]    st_in;
   logic [7:0]    ph_in, mask_in;
   logic [63:0]   pt_in, now_in;
   logic          do_ins, do_pop;
   logic          exec_go;

   assign qok = (32'(q_ff) < NUM_QUEUES);
   assign qi  = QW'(q_ff);

   // Execute once the response register is free or being emptied
   assign exec_go = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp.ready);

   for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_q
      assign ne[q]  = fills[q] != '0;
      assign due[q] = ne[q] && heads[q].time_v == now_ff;
      assign at_min[q] = ne[q] && heads[q].time_v == earliest;
      assign ops[q] = '{ins: do_ins && qi == QW'(q), pop: do_pop && qi == QW'(q),
                        ins_time: t_ff, ins_handle: h_ff};
      teqs_queue u_queue (.clock, .reset, .op(ops[q]), .head(heads[q]), .fill(fills[q]));
   end

   // Earliest head over all non-empty queues
   always_comb begin
      earliest = FF64;
      for (int q = 0; q < NUM_QUEUES; q++) begin
         if (ne[q] && heads[q].time_v < earliest) earliest = heads[q].time_v;
      end
   end

   // Command decode for the execute cycle
   always_comb begin
      do_ins  = 1'b0;
      do_pop  = 1'b0;
      st_in   = ST_NONE;
      ph_in   = '0;
      pt_in   = '0;
      mask_in = '0;
      now_in  = now_ff;
      case (cmd_type'(cmd_ff))
         CMD_INSERT: begin
            if (qok && fills[qi] < FW'(QUEUE_DEPTH)) begin
               do_ins = exec_go;
               st_in  = ST_OK;
            end else begin
               st_in = ST_FULL;
            end
         end
         CMD_POP: begin
            if (qok && ne[qi] && heads[qi].time_v == now_ff) begin
               do_pop = exec_go;
               st_in  = ST_OK;
               ph_in  = heads[qi].handle;
               pt_in  = heads[qi].time_v;
            end
         end
         CMD_ADVANCE: begin
            if (ne == '0) begin
               st_in = ST_EMPTY_ALL;
            end else if (due != '0) begin
               st_in   = ST_OK;
               mask_in = 8'(due);
            end else begin
               st_in   = ST_OK;
               mask_in = 8'(at_min);
               now_in  = earliest;
            end
         end
         default: st_in = ST_NONE;
      endcase
   end

   assign req.ready         = (state_ff == S_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = st_ff;
   assign rsp.popped_handle = ph_ff;
   assign rsp.popped_time   = pt_ff;
   assign rsp.due_mask      = mask_ff;
   assign rsp.time_now      = now_ff;

   // Sequencer, request capture and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (exec_go) begin
            st_ff        <= st_in;
            ph_ff        <= ph_in;
            pt_ff        <= pt_in;
            mask_ff      <= mask_in;
            now_ff       <= now_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  cmd_ff   <= req.command;
                  q_ff     <= req.queue_index;
                  t_ff     <= req.event_time;
                  h_ff     <= req.event_handle;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (exec_go) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* hdl/teqs_checker.sv */
// Checker: port-level properties of the scheduler, bound to the top level
module teqs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_due_mask,
   input logic [63:0] rsp_time_now
);
   import teqs_pkg::*;

   // One request in execute: no acceptance in the cycle after one is taken
   a_excl: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("request taken back to back");

   // A request taken with the response side free passes through execute without stall to a valid response
   a_lat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (!rsp_valid || rsp_ready)) |=> ##1 rsp_valid)
      else $error("response missing");

   // No-events status carries no due mask
   a_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY_ALL) |-> rsp_due_mask == '0)
      else $error("due mask with empty queues");

   // Stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_time_now))
      else $error("response changed while stalled");
endmodule

bind timed_event_queue_scheduler_core teqs_checker u_teqs_checker (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_due_mask(rsp.due_mask), .rsp_time_now(rsp.time_now)
);
